// ----- rtl/core/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the greedy box suppression block
// Holds default sizes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned MaxKeptDefault = 256;
  localparam logic [15:0] IouThresholdReset = 16'd29491;
  localparam int unsigned CoordWidth = 15;
  localparam int unsigned AreaWidth = 30;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input box
    logic clear_acc; // start a new scan over kept boxes
    logic compare;   // registered compare of the entry read last cycle
    logic read_en;   // read one kept entry
    logic finish;    // decide, store and build the result
  } gbn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;   // every kept entry has been read
    logic pipe_empty;  // no compare still in flight
  } gbn_status_t;

endpackage

// ----- rtl/core/gbn_datapath.sv -----
// ----------------------------------------------------------------------------
// gbn_datapath: box store, overlap test pipeline and frame counters
// Reads one kept box per cycle and tests IoU against the threshold.
// ----------------------------------------------------------------------------
module gbn_datapath #(
  parameter int unsigned MAX_KEPT = gbn_pkg::MaxKeptDefault,
  parameter int unsigned IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  parameter int unsigned CNT_W = $clog2(MAX_KEPT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  gbn_pkg::gbn_cmd_t    cmd,
  output gbn_pkg::gbn_status_t status,
  input  logic [15:0]         iou_threshold,
  input  logic signed [14:0]  in_x,
  input  logic signed [14:0]  in_y,
  input  logic [14:0]         in_w,
  input  logic [14:0]         in_h,
  input  logic                in_last,
  output logic                res_keep,
  output logic [15:0]         res_index,
  output logic                res_full,
  output logic                res_end,
  output logic [8:0]          res_total
);
  import gbn_pkg::*;

  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  box_t        cur;
  logic        cur_last;
  logic [29:0] cur_area;
  box_t        mem_box [MAX_KEPT];
  logic [29:0] mem_area [MAX_KEPT];
  box_t        rd_box;
  logic [29:0] rd_area;
  logic        rd_valid;
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] scan;
  logic [15:0] frame_position;
  logic        hit;
  logic        store_ok;
  logic        st1_valid;
  logic [29:0] st1_inter;
  logic [30:0] st1_union;
  logic        st2_valid;
  logic [46:0] st2_lhs;
  logic [46:0] st2_rhs;

  // Overlap spans of the stored box against the current box.
  logic signed [16:0] ax1, ay1, bx1, by1, lox, hix, loy, hiy;
  logic [16:0] iw, ih;
  logic [29:0] inter;
  always_comb begin
    ax1 = 17'(cur.x) + 17'($signed({2'b0, cur.w}));
    ay1 = 17'(cur.y) + 17'($signed({2'b0, cur.h}));
    bx1 = 17'(rd_box.x) + 17'($signed({2'b0, rd_box.w}));
    by1 = 17'(rd_box.y) + 17'($signed({2'b0, rd_box.h}));
    lox = (17'(cur.x) > 17'(rd_box.x)) ? 17'(cur.x) : 17'(rd_box.x);
    loy = (17'(cur.y) > 17'(rd_box.y)) ? 17'(cur.y) : 17'(rd_box.y);
    hix = (ax1 < bx1) ? ax1 : bx1;
    hiy = (ay1 < by1) ? ay1 : by1;
    iw = (hix > lox) ? 17'(hix - lox) : 17'd0;
    ih = (hiy > loy) ? 17'(hiy - loy) : 17'd0;
    inter = 30'(iw[14:0]) * 30'(ih[14:0]);
  end

  assign status.scan_done  = (scan >= kept_count);
  assign status.pipe_empty = !rd_valid && !st1_valid && !st2_valid;

  // The current box is stored when nothing suppressed it and there is room.
  assign store_ok = !hit && (kept_count < CNT_W'(MAX_KEPT));

  // Box store: written on keep, read one entry per cycle during the scan.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_box  <= mem_box[scan[IDX_W-1:0]];
      rd_area <= mem_area[scan[IDX_W-1:0]];
    end
    if (cmd.finish && store_ok) begin
      mem_box[kept_count[IDX_W-1:0]]  <= cur;
      mem_area[kept_count[IDX_W-1:0]] <= cur_area;
    end
  end

  // Input capture, compare pipeline and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      frame_position <= '0;
      scan <= '0;
      rd_valid <= 1'b0;
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      rd_valid <= cmd.read_en;
      st1_valid <= rd_valid && cmd.compare;
      st1_inter <= inter;
      st1_union <= 31'(cur_area) + 31'(rd_area) - 31'(inter);
      st2_valid <= st1_valid;
      st2_lhs <= {1'b0, st1_inter, 16'd0};
      st2_rhs <= 47'(iou_threshold) * 47'(st1_union);
      if (cmd.clear_acc) begin
        scan <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.read_en) scan <= scan + 1'b1;
        if (st2_valid && st2_lhs > st2_rhs) hit <= 1'b1;
      end
      if (cmd.load) begin
        cur <= '{x: in_x, y: in_y, w: in_w, h: in_h};
        cur_area <= 30'(in_w * in_h);
        cur_last <= in_last;
      end
      if (cmd.finish) begin
        res_index <= frame_position;
        res_end   <= cur_last;
        res_keep  <= store_ok;
        res_full  <= !hit && !store_ok;
        if (store_ok) res_total <= 9'(kept_count + 1'b1);
        else res_total <= 9'(kept_count);
        // The last box of a frame empties the store and restarts the count.
        if (cur_last) begin
          kept_count <= '0;
          frame_position <= '0;
        end else begin
          if (store_ok) kept_count <= kept_count + 1'b1;
          if (frame_position != 16'hFFFF) frame_position <= frame_position + 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CNT_W'(MAX_KEPT)) else $error("kept count beyond store");
  a_pipe_follow: assert property (@(posedge clk) disable iff (rst)
    st1_valid |=> st2_valid) else $error("compare stage lost");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !rd_valid && !st1_valid && !st2_valid)
    else $error("result built with compares in flight");
`endif
endmodule

// ----- rtl/core/gbn_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbn_ctrl: sequencer for input transfer, store scan and result hand-off
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gbn_pkg::gbn_cmd_t     cmd,
  input  gbn_pkg::gbn_status_t  status
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;
  state_t state;

  // A new box may enter when idle and the held result is absent or leaves.
  logic take;
  assign in_stall = !(state == S_IDLE && (!out_valid || !out_stall));
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load = take;
    cmd.clear_acc = take;
    cmd.compare = 1'b1;
    cmd.read_en = (state == S_SCAN) && !status.scan_done;
    cmd.finish = (state == S_DRAIN) && status.pipe_empty;
  end

  // State and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (take) state <= S_SCAN;
        S_SCAN: if (status.scan_done) state <= S_DRAIN;
        S_DRAIN: if (status.pipe_empty) state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("transfer taken while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not presented");
  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !cmd.finish) else $error("double finish");
`endif
endmodule

// ----- rtl/core/greedy_box_nms.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms: greedy non-maximum suppression by IoU threshold
// Channel | direction | handshake
// box     | in        | in_valid / in_stall, fields box_*, last_box
// result  | out       | out_valid / out_stall, keep .. kept_total
// config  | in        | cfg_valid / cfg_ready, cfg_data = iou_threshold
// After a box transfer the store is scanned one entry per cycle through a
// three-stage compare pipe, then drained, before the result is built.
// A finished result waits in the output register; the next box enters when
// the block is idle and that register is free or being taken. Reset is
// synchronous and needs no clearing pass; the threshold returns to 29491.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
  parameter int unsigned MAX_KEPT = gbn_pkg::MaxKeptDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] box_x,
  input  logic signed [14:0] box_y,
  input  logic [14:0]        box_w,
  input  logic [14:0]        box_h,
  input  logic               last_box,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               keep,
  output logic [15:0]        box_index,
  output logic               store_full,
  output logic               frame_end,
  output logic [8:0]         kept_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import gbn_pkg::*;

  gbn_cmd_t    cmd;
  gbn_status_t status;
  logic [15:0] iou_threshold;

  // Threshold register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) iou_threshold <= IouThresholdReset;
    else if (cfg_valid && cfg_ready) iou_threshold <= cfg_data;
  end

  gbn_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .status
  );

  gbn_datapath #(.MAX_KEPT(MAX_KEPT)) u_dp (
    .clk, .rst, .cmd, .status, .iou_threshold,
    .in_x(box_x), .in_y(box_y), .in_w(box_w), .in_h(box_h), .in_last(last_box),
    .res_keep(keep), .res_index(box_index), .res_full(store_full),
    .res_end(frame_end), .res_total(kept_total)
  );
endmodule

// ----- tb/greedy_box_nms_checker.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms_checker: result predictor and scoreboard for greedy_box_nms
// Watches the box, result and threshold channels. Every accepted box is run
// through a local model of the suppression store, and every accepted result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module greedy_box_nms_checker #(
  parameter int unsigned MAX_KEPT = gbn_pkg::MaxKeptDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [14:0] box_x,
  input  logic signed [14:0] box_y,
  input  logic [14:0]        box_w,
  input  logic [14:0]        box_h,
  input  logic               last_box,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               keep,
  input  logic [15:0]        box_index,
  input  logic               store_full,
  input  logic               frame_end,
  input  logic [8:0]         kept_total,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 verdicts_waiting,
  output int                 verdicts_seen,
  output int                 kept_seen,
  output int                 full_seen
);

  typedef struct packed {
    logic        keep;
    logic [15:0] index;
    logic        full;
    logic        frame_end;
    logic [8:0]  total;
  } verdict_t;

  // Local copy of the suppression store and the threshold register.
  logic [15:0]  thr;
  int           kx   [MAX_KEPT];
  int           ky   [MAX_KEPT];
  int           kw   [MAX_KEPT];
  int           kh   [MAX_KEPT];
  longint       karea[MAX_KEPT];
  int unsigned  nkept;
  int unsigned  fpos;
  verdict_t     verdict_q[$];

  assign verdicts_waiting = verdict_q.size();

  // Intersection length of two spans, zero when they only touch or miss.
  function automatic longint overlap_len(int a0, int a1, int b0, int b1);
    int lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  // Judge one box against the store and update the store and counters.
  function automatic verdict_t judge_box(int x, int y, int w, int h, logic last);
    verdict_t v;
    longint   area, inter, uni;
    logic     survive;
    survive = 1'b1;
    area    = longint'(w) * longint'(h);
    for (int k = 0; k < nkept; k++) begin
      inter = overlap_len(x, x + w, kx[k], kx[k] + kw[k]) *
              overlap_len(y, y + h, ky[k], ky[k] + kh[k]);
      uni = area + karea[k] - inter;
      if ((inter << 16) > longint'(thr) * uni) survive = 1'b0;
    end
    v.full = 1'b0;
    if (survive) begin
      if (nkept >= MAX_KEPT) begin
        survive = 1'b0;
        v.full  = 1'b1;
      end else begin
        kx[nkept]    = x;
        ky[nkept]    = y;
        kw[nkept]    = w;
        kh[nkept]    = h;
        karea[nkept] = area;
        nkept++;
      end
    end
    v.keep      = survive;
    v.index     = fpos[15:0];
    v.frame_end = last;
    v.total     = nkept[8:0];
    if (fpos < 65535) fpos++;
    if (last) begin
      nkept = 0;
      fpos  = 0;
    end
    return v;
  endfunction

  // Sample all three channels at the clock edge.
  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      thr           = gbn_pkg::IouThresholdReset;
      nkept         = 0;
      fpos          = 0;
      fail_count    = 0;
      verdicts_seen = 0;
      kept_seen     = 0;
      full_seen     = 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) thr = cfg_data;
      if (in_valid && !in_stall)
        verdict_q = {verdict_q, judge_box(int'(box_x), int'(box_y), int'(box_w),
                                          int'(box_h), last_box)};
      if (out_valid && !out_stall) begin
        got = '{keep, box_index, store_full, frame_end, kept_total};
        verdicts_seen++;
        if (keep) kept_seen++;
        if (store_full) full_seen++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("MISMATCH: result transfer with nothing expected (index %0d)",
                     box_index);
        end else begin
          want = verdict_q.pop_front();
          if (got.keep !== want.keep || got.index !== want.index ||
              got.full !== want.full || got.frame_end !== want.frame_end ||
              got.total !== want.total) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"MISMATCH: expected keep=%0d index=%0d full=%0d end=%0d ",
                        "total=%0d, got keep=%0d index=%0d full=%0d end=%0d total=%0d"},
                       want.keep, want.index, want.full, want.frame_end, want.total,
                       got.keep, got.index, got.full, got.frame_end, got.total);
          end
        end
      end
    end
  end

endmodule

// ----- tb/greedy_box_nms_tb.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms_tb: stimulus and verdict for the greedy box suppression block
// Drives directed boxes, a store-filling frame and random clustered frames
// under several IoU thresholds, with random gaps on the box channel and
// random result stalls.
// ----------------------------------------------------------------------------
module greedy_box_nms_tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [14:0] box_x;
  logic signed [14:0] box_y;
  logic [14:0]        box_w;
  logic [14:0]        box_h;
  logic               last_box;
  logic               out_valid;
  logic               out_stall;
  logic               keep;
  logic [15:0]        box_index;
  logic               store_full;
  logic               frame_end;
  logic [8:0]         kept_total;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  int fail_count, verdicts_waiting, verdicts_seen, kept_seen, full_seen;
  int boxes_sent;
  bit quiet;

  greedy_box_nms u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
    .last_box(last_box),
    .out_valid(out_valid), .out_stall(out_stall),
    .keep(keep), .box_index(box_index), .store_full(store_full),
    .frame_end(frame_end), .kept_total(kept_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  greedy_box_nms_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
    .last_box(last_box),
    .out_valid(out_valid), .out_stall(out_stall),
    .keep(keep), .box_index(box_index), .store_full(store_full),
    .frame_end(frame_end), .kept_total(kept_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .verdicts_waiting(verdicts_waiting),
    .verdicts_seen(verdicts_seen), .kept_seen(kept_seen), .full_seen(full_seen)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Mostly short gaps, now and then a long one; none in quiet stretches.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side stall in bursts of random length.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !quiet && ($urandom_range(0, 2) == 0);
      stall_left <= gap_len();
    end
  end

  // One box transfer followed by a random gap.
  task automatic send_box(int x, int y, int w, int h, bit last);
    int n;
    in_valid <= 1'b1;
    box_x    <= x[14:0];
    box_y    <= y[14:0];
    box_w    <= w[14:0];
    box_h    <= h[14:0];
    last_box <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    boxes_sent++;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait until every result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Threshold write, only issued with the block idle.
  task automatic write_threshold(int unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Frame of boxes jittered around one center so that overlaps are common.
  task automatic random_frame();
    int nbox, cx, cy, r;
    nbox = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    cx   = $urandom_range(0, 2000) - 1000;
    cy   = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < nbox; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_box($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                 $urandom_range(0, 32767), $urandom_range(0, 32767), i == nbox - 1);
      else if (r < 12)
        send_box(cx, cy, $urandom_range(0, 1) * $urandom_range(0, 300), 0,
                 i == nbox - 1);
      else
        send_box(cx + $urandom_range(0, 160) - 80, cy + $urandom_range(0, 160) - 80,
                 $urandom_range(40, 400), $urandom_range(40, 400), i == nbox - 1);
    end
  endtask

  initial begin
    rst        = 1'b1;
    quiet      = 1'b0;
    boxes_sent = 0;
    in_valid   = 1'b0;
    box_x      = '0;
    box_y      = '0;
    box_w      = '0;
    box_h      = '0;
    last_box   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset threshold: extremes, identical, touching,
    // disjoint and zero-area boxes.
    send_box(-16384, -16384, 32767, 32767, 0);
    send_box(-16384, -16384, 32767, 32767, 0);
    send_box(16383, 16383, 32767, 32767, 0);
    send_box(16383, -16384, 0, 0, 0);
    send_box(16383, -16384, 0, 0, 0);
    send_box(100, 100, 0, 500, 0);
    send_box(-16384, 16383, 16, 16, 0);
    send_box(-16368, 16383, 16, 16, 0);
    send_box(-16376, 16383, 16, 16, 1);
    send_box(0, 0, 160, 160, 1);

    // Everything that overlaps at all is suppressed at threshold zero.
    write_threshold(0);
    send_box(0, 0, 160, 160, 0);
    send_box(159, 159, 160, 160, 0);
    send_box(160, 0, 160, 160, 0);
    send_box(0, 0, 0, 0, 1);

    // At the top threshold only near-identical boxes are suppressed.
    write_threshold(65535);
    send_box(0, 0, 160, 160, 0);
    send_box(0, 0, 160, 160, 0);
    send_box(1, 0, 160, 160, 1);

    // Disjoint boxes until the store overflows.
    write_threshold(gbn_pkg::IouThresholdReset);
    for (int i = 0; i < 260; i++)
      send_box((i % 16) * 64, (i / 16) * 64, 32, 32, i == 259);

    // Random frames under changing thresholds.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_threshold($urandom_range(0, 65535));
        1: write_threshold(0);
        2: write_threshold(65535);
        3: write_threshold(gbn_pkg::IouThresholdReset);
        default: write_threshold($urandom_range(0, 65535));
      endcase
      quiet = (phase == 4);
      for (int f = 0; f < 2; f++) random_frame();
    end
    drain();

    $display("Run covered %0d boxes and %0d checked results: %0d kept, %0d store-full.",
             boxes_sent, verdicts_seen, kept_seen, full_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/gbn_pkg.sv
rtl/core/gbn_datapath.sv
rtl/core/gbn_ctrl.sv
rtl/core/greedy_box_nms.sv
tb/greedy_box_nms_checker.sv
tb/greedy_box_nms_tb.sv
